// ===== rtl/r2q_pkg.sv =====
package r2q_pkg;

  localparam int INDEX_BITS = 20;
  localparam int FRAC_BITS  = 16;

  // coordinates are accumulated in q0.32 and wrap modulo one
  localparam int COORD_BITS = 32;
  localparam logic [COORD_BITS-1:0] STEP_X   = 32'd3242174889;  // 1/g
  localparam logic [COORD_BITS-1:0] STEP_Y   = 32'd2447445413;  // 1/g^2
  localparam logic [COORD_BITS-1:0] HALF_Q32 = 32'h8000_0000;
  localparam logic [COORD_BITS-1:0] SCALE_DEFAULT_Q32 = 32'd3143916061;  // 0.732
  localparam logic [FRAC_BITS-1:0]  SCALE_RESET =
      SCALE_DEFAULT_Q32[COORD_BITS-1 -: FRAC_BITS];

  // reciprocal square root in q1.16
  localparam int RSQRT_FRAC = 16;
  localparam int RSQRT_BITS = RSQRT_FRAC + 1;

  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 3;

  typedef enum logic {
    REG_JITTER_ENABLE = 1'b0,
    REG_JITTER_SCALE  = 1'b1
  } reg_addr_e;

  typedef struct packed {
    logic [INDEX_BITS-1:0] sample_index;
    logic [FRAC_BITS-1:0]  jitter_x;
    logic [FRAC_BITS-1:0]  jitter_y;
  } in_item_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0]  point_x;
    logic [FRAC_BITS-1:0]  point_y;
    logic [INDEX_BITS-1:0] point_index;
  } out_item_t;

endpackage

// ===== rtl/r2q_rsqrt.sv =====
module r2q_rsqrt import r2q_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  in_item_t              item_i,
  output logic                  valid_o,
  output in_item_t              item_o,
  output logic [RSQRT_BITS-1:0] root_o
);

  // restoring division of 2^32 by (index + 1), one quotient bit a stage
  localparam int NW          = INDEX_BITS + 1;
  localparam int QW          = COORD_BITS + 1;
  localparam int DIV_STAGES  = QW;
  // digit-by-digit square root of the quotient, one root bit a stage
  localparam int SQRT_STAGES = RSQRT_BITS;
  localparam int RADW        = 2 * SQRT_STAGES;
  localparam int RW          = RSQRT_BITS + 2;

  logic            div_vld_q  [DIV_STAGES];
  logic [NW-1:0]   div_rem_q  [DIV_STAGES];
  logic [NW-1:0]   div_n_q    [DIV_STAGES];
  logic [QW-1:0]   div_quot_q [DIV_STAGES];
  in_item_t        div_item_q [DIV_STAGES];

  logic                  sq_vld_q  [SQRT_STAGES];
  logic [RW-1:0]         sq_rem_q  [SQRT_STAGES];
  logic [RADW-1:0]       sq_rad_q  [SQRT_STAGES];
  logic [RSQRT_BITS-1:0] sq_root_q [SQRT_STAGES];
  in_item_t              sq_item_q [SQRT_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic          vld_in;
    logic [NW-1:0] rem_in;
    logic [NW-1:0] n_in;
    logic [QW-1:0] quot_in;
    in_item_t      item_in;
    logic [NW:0]   shifted;
    logic          take;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign n_in    = {1'b0, item_i.sample_index} + NW'(1);
      assign quot_in = '0;
      assign item_in = item_i;
    end else begin : g_next
      assign vld_in  = div_vld_q[s-1];
      assign rem_in  = div_rem_q[s-1];
      assign n_in    = div_n_q[s-1];
      assign quot_in = div_quot_q[s-1];
      assign item_in = div_item_q[s-1];
    end

    // the dividend has a single set bit, at its top
    assign shifted = {rem_in, (s == 0) ? 1'b1 : 1'b0};
    assign take    = shifted >= {1'b0, n_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_vld_q[s] <= 1'b0;
      end else if (en_i) begin
        div_vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_rem_q[s]  <= take ? NW'(shifted - {1'b0, n_in}) : NW'(shifted);
        div_n_q[s]    <= n_in;
        div_quot_q[s] <= {quot_in[QW-2:0], take};
        div_item_q[s] <= item_in;
      end
    end
  end

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
    logic                  vld_in;
    logic [RW-1:0]         rem_in;
    logic [RADW-1:0]       rad_in;
    logic [RSQRT_BITS-1:0] root_in;
    in_item_t              item_in;
    logic [RW+1:0]         shifted;
    logic [RW+1:0]         trial;
    logic                  take;

    if (s == 0) begin : g_first
      assign vld_in  = div_vld_q[DIV_STAGES-1];
      assign rem_in  = '0;
      assign rad_in  = RADW'(div_quot_q[DIV_STAGES-1]);
      assign root_in = '0;
      assign item_in = div_item_q[DIV_STAGES-1];
    end else begin : g_next
      assign vld_in  = sq_vld_q[s-1];
      assign rem_in  = sq_rem_q[s-1];
      assign rad_in  = sq_rad_q[s-1];
      assign root_in = sq_root_q[s-1];
      assign item_in = sq_item_q[s-1];
    end

    assign shifted = {rem_in, rad_in[RADW-1 -: 2]};
    assign trial   = {2'b00, root_in, 2'b01};
    assign take    = shifted >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[s] <= 1'b0;
      end else if (en_i) begin
        sq_vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_rem_q[s]  <= take ? RW'(shifted - trial) : RW'(shifted);
        sq_rad_q[s]  <= {rad_in[RADW-3:0], 2'b00};
        sq_root_q[s] <= {root_in[RSQRT_BITS-2:0], take};
        sq_item_q[s] <= item_in;
      end
    end
  end

  assign valid_o = sq_vld_q[SQRT_STAGES-1];
  assign item_o  = sq_item_q[SQRT_STAGES-1];
  assign root_o  = sq_root_q[SQRT_STAGES-1];

  localparam logic [RSQRT_BITS-1:0] ONE_Q16 = RSQRT_BITS'(1) << RSQRT_FRAC;

  a_div_rem_below_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld_q[DIV_STAGES-1] |-> div_rem_q[DIV_STAGES-1] < div_n_q[DIV_STAGES-1])
    else $error("divider remainder not below divisor");

  a_root_at_most_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> root_o <= ONE_Q16)
    else $error("rsqrt above one");

  a_root_index_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && item_o.sample_index == '0) |-> root_o == ONE_Q16)
    else $error("rsqrt of one is not exactly one");

endmodule

// ===== rtl/r2q_lane.sv =====
module r2q_lane import r2q_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic                  jitter_enable_i,
  input  logic [FRAC_BITS-1:0]  jitter_scale_i,
  input  logic [COORD_BITS-1:0] step_i,
  input  logic [INDEX_BITS-1:0] index_i,
  input  logic [FRAC_BITS-1:0]  jitter_i,
  input  logic [RSQRT_BITS-1:0] root_i,
  output logic [FRAC_BITS-1:0]  coord_o
);

  localparam int JSW   = 2 * FRAC_BITS;
  localparam int PW    = JSW + RSQRT_BITS;
  localparam int SHIFT = JSW - RSQRT_FRAC;

  logic [COORD_BITS+INDEX_BITS-1:0] base_full;
  logic [JSW-1:0]                   js_full;
  logic [PW-1:0]                    prod_full;

  logic [COORD_BITS-1:0] base1_q, base2_q, coord_q;
  logic [JSW-1:0]        js_q;
  logic [RSQRT_BITS-1:0] root_q;
  logic [COORD_BITS-1:0] off_q;

  assign base_full = step_i * index_i;
  assign js_full   = jitter_i * jitter_scale_i;
  assign prod_full = js_q * root_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base1_q <= base_full[COORD_BITS-1:0];
      js_q    <= js_full;
      root_q  <= root_i;
      base2_q <= base1_q;
      off_q   <= prod_full[SHIFT +: COORD_BITS];
      // wraps modulo one
      coord_q <= base2_q + (jitter_enable_i ? off_q : HALF_Q32);
    end
  end

  assign coord_o = coord_q[COORD_BITS-1 -: FRAC_BITS];

endmodule

// ===== rtl/r2_quasirandom_sample_gen.sv =====
// channel   direction  payload      handshake
// in        input      in_item_t    in_valid_i / in_stall_o
// out       output     out_item_t   out_valid_o / out_stall_i
// cfg       input      apb write    psel, penable, pwrite, pready
//
// one transaction per cycle sustained while in_stall_o is low; a point passes
// through the 33-stage divider and 17-stage square root, then through the
// two coordinate lanes and the output register.
// reset clears all valid bits and loads jitter_enable = 0, scale = 0.732.
// a stall is absorbed by a one-entry skid; in_stall_o rises only once the
// skid holds a point, and the whole pipeline then freezes.
module r2_quasirandom_sample_gen import r2q_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam int LANE_STAGES = 3;

  logic                 jitter_enable_q;
  logic [FRAC_BITS-1:0] jitter_scale_q;
  reg_addr_e            reg_sel;

  logic                  en;
  logic                  rs_valid;
  in_item_t              rs_item;
  logic [RSQRT_BITS-1:0] rs_root;

  logic                  lane_vld_q [LANE_STAGES];
  logic [INDEX_BITS-1:0] lane_idx_q [LANE_STAGES];
  logic [FRAC_BITS-1:0]  coord_x, coord_y;
  out_item_t             tail;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t skid_q, skid_d;
  logic      take;

  // configuration
  assign pready  = 1'b1;
  assign reg_sel = reg_addr_e'(paddr[2]);
  assign prdata  = (reg_sel == REG_JITTER_SCALE) ? DATA_BITS'(jitter_scale_q)
                                                 : DATA_BITS'(jitter_enable_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jitter_enable_q <= 1'b0;
      jitter_scale_q  <= SCALE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_JITTER_ENABLE: jitter_enable_q <= pwdata[0];
        REG_JITTER_SCALE:  jitter_scale_q  <= pwdata[FRAC_BITS-1:0];
      endcase
    end
  end

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  r2q_rsqrt u_rsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_data_i),
    .valid_o (rs_valid),
    .item_o  (rs_item),
    .root_o  (rs_root)
  );

  r2q_lane u_lane_x (
    .clk_i           (clk_i),
    .en_i            (en),
    .jitter_enable_i (jitter_enable_q),
    .jitter_scale_i  (jitter_scale_q),
    .step_i          (STEP_X),
    .index_i         (rs_item.sample_index),
    .jitter_i        (rs_item.jitter_x),
    .root_i          (rs_root),
    .coord_o         (coord_x)
  );

  r2q_lane u_lane_y (
    .clk_i           (clk_i),
    .en_i            (en),
    .jitter_enable_i (jitter_enable_q),
    .jitter_scale_i  (jitter_scale_q),
    .step_i          (STEP_Y),
    .index_i         (rs_item.sample_index),
    .jitter_i        (rs_item.jitter_y),
    .root_i          (rs_root),
    .coord_o         (coord_y)
  );

  // index and valid ride alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LANE_STAGES; s++) lane_vld_q[s] <= 1'b0;
    end else if (en) begin
      lane_vld_q[0] <= rs_valid;
      for (int s = 1; s < LANE_STAGES; s++) lane_vld_q[s] <= lane_vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lane_idx_q[0] <= rs_item.sample_index;
      for (int s = 1; s < LANE_STAGES; s++) lane_idx_q[s] <= lane_idx_q[s-1];
    end
  end

  // merge the two lanes into one point
  assign tail.point_x     = coord_x;
  assign tail.point_y     = coord_y;
  assign tail.point_index = lane_idx_q[LANE_STAGES-1];

  assign take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    priority if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (lane_vld_q[LANE_STAGES-1]) begin
      if (!out_valid_q || take) begin
        out_valid_d = 1'b1;
        out_d       = tail;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = tail;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a point while output is empty");

  a_skid_fill_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i && lane_vld_q[LANE_STAGES-1]))
    else $error("skid filled without a stalled output");

  a_skid_drain_refills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && take) |=> (out_valid_q && !skid_valid_q))
    else $error("skid drain lost a point");

endmodule
